>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: %m");
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: %m");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: %m");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> sv/sexp_pkg.sv
// ---------------------------------------------------------------------------
// sexp_pkg
// Types and constants shared by the s-expression tokenizer modules.
// ---------------------------------------------------------------------------
package sexp_pkg;

  localparam int TOKEN_BUFFER_SIZE = 1024;
  localparam int MAX_CHARS_W       = 10;
  localparam logic [MAX_CHARS_W-1:0] MAX_CHARS_RESET =
    (TOKEN_BUFFER_SIZE - 1 > 1023) ? MAX_CHARS_W'(1023) : MAX_CHARS_W'(TOKEN_BUFFER_SIZE - 1);

  localparam logic [2:0] KIND_ERROR   = 3'd0;
  localparam logic [2:0] KIND_STRING  = 3'd1;
  localparam logic [2:0] KIND_NUMBER  = 3'd2;
  localparam logic [2:0] KIND_SYMBOL  = 3'd3;
  localparam logic [2:0] KIND_SPECIAL = 3'd4;

  // Result queue: must hold the two results of one request on top of two already waiting.
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_SYMBOL = 2'd1,
    MODE_STRING = 2'd2,
    MODE_NUMBER = 2'd3
  } lex_mode_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [2:0] token_kind;
    logic       has_char;
    logic [7:0] char_out;
    logic       token_end;
  } out_item_t;

  typedef struct packed {
    logic      v0;
    logic      v1;
    out_item_t r0;
    out_item_t r1;
  } lex_push_t;

endpackage

>>> sv/sexp_lexer_core.sv
// ---------------------------------------------------------------------------
// sexp_lexer_core
// Lexer state and one-byte decode; yields up to two results per request.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sexp_lexer_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  sexp_pkg::in_item_t                item,
  input  logic                              cfg_write_en,
  input  logic [sexp_pkg::MAX_CHARS_W-1:0]  cfg_write_data,
  output sexp_pkg::lex_push_t               push
);

  sexp_pkg::lex_mode_t                mode, mode_next;
  logic                               escape_pending, escape_pending_next;
  logic [2:0]                         current_kind, current_kind_next;
  logic [sexp_pkg::MAX_CHARS_W-1:0]   chars_in_token, chars_in_token_next;
  logic [sexp_pkg::MAX_CHARS_W-1:0]   max_token_chars;

  logic                to_idle;
  logic                room;
  logic                cap_nonzero;
  logic [7:0]          c;
  logic                c_space, c_digit, c_special, c_bslash, c_dquote;
  sexp_pkg::out_item_t char_res, close_res, err_res, spec_res;

  assign c           = item.char_in;
  assign c_space     = (c == 8'h00) || (c == 8'h20) || (c == 8'h09) ||
                       (c == 8'h0A) || (c == 8'h0D);
  assign c_digit     = (c >= 8'h30) && (c <= 8'h39);
  assign c_special   = (c == 8'h2C) || (c == 8'h27) || (c == 8'h28) || (c == 8'h29);
  assign c_bslash    = (c == 8'h5C);
  assign c_dquote    = (c == 8'h22);
  assign room        = chars_in_token < max_token_chars;
  assign cap_nonzero = max_token_chars != '0;

  always_comb begin
    char_res  = '{token_kind: current_kind, has_char: 1'b1, char_out: c, token_end: 1'b0};
    close_res = '{token_kind: current_kind, has_char: 1'b0, char_out: 8'h00, token_end: 1'b1};
    err_res   = '{token_kind: sexp_pkg::KIND_ERROR, has_char: 1'b0, char_out: 8'h00,
                  token_end: 1'b1};
    spec_res  = '{token_kind: sexp_pkg::KIND_SPECIAL, has_char: cap_nonzero,
                  char_out: cap_nonzero ? c : 8'h00, token_end: 1'b1};
  end

  always_comb begin
    mode_next           = mode;
    escape_pending_next = escape_pending;
    current_kind_next   = current_kind;
    chars_in_token_next = chars_in_token;
    to_idle             = 1'b0;
    push                = '0;
    if (accept) begin
      if (item.end_of_input) begin
        if (mode != sexp_pkg::MODE_IDLE) begin
          push.v0 = 1'b1;
          push.r0 = close_res;
          to_idle = 1'b1;
        end
      end else begin
        unique case (mode)
          sexp_pkg::MODE_STRING: begin
            if (escape_pending) begin
              escape_pending_next = 1'b0;
              if (room) begin
                push.v0             = 1'b1;
                push.r0             = char_res;
                chars_in_token_next = chars_in_token + sexp_pkg::MAX_CHARS_W'(1);
              end
            end else if (c_dquote) begin
              push.v0 = 1'b1;
              push.r0 = close_res;
              to_idle = 1'b1;
            end else if (c_bslash) begin
              escape_pending_next = 1'b1;
            end else if (room) begin
              push.v0             = 1'b1;
              push.r0             = char_res;
              chars_in_token_next = chars_in_token + sexp_pkg::MAX_CHARS_W'(1);
            end
          end
          sexp_pkg::MODE_SYMBOL, sexp_pkg::MODE_NUMBER: begin
            if (c_bslash) begin
              push.v0 = 1'b1;
              push.r0 = err_res;
              to_idle = 1'b1;
            end else if (c_space || c_special) begin
              // close the token, then handle the delimiter from idle
              push.v0 = 1'b1;
              push.r0 = close_res;
              push.v1 = c_special;
              push.r1 = spec_res;
              to_idle = 1'b1;
            end else if (mode == sexp_pkg::MODE_SYMBOL || c_digit) begin
              if (room) begin
                push.v0             = 1'b1;
                push.r0             = char_res;
                chars_in_token_next = chars_in_token + sexp_pkg::MAX_CHARS_W'(1);
              end
            end else begin
              push.v0 = 1'b1;
              push.r0 = err_res;
              to_idle = 1'b1;
            end
          end
          sexp_pkg::MODE_IDLE: begin
            if (c_bslash) begin
              push.v0 = 1'b1;
              push.r0 = err_res;
            end else if (c_dquote) begin
              mode_next           = sexp_pkg::MODE_STRING;
              current_kind_next   = sexp_pkg::KIND_STRING;
              chars_in_token_next = '0;
              escape_pending_next = 1'b0;
            end else if (c_space) begin
              mode_next = sexp_pkg::MODE_IDLE;
            end else if (c_special) begin
              push.v0 = 1'b1;
              push.r0 = spec_res;
            end else begin
              // open a number or symbol with this byte as its first character
              mode_next           = c_digit ? sexp_pkg::MODE_NUMBER : sexp_pkg::MODE_SYMBOL;
              current_kind_next   = c_digit ? sexp_pkg::KIND_NUMBER : sexp_pkg::KIND_SYMBOL;
              escape_pending_next = 1'b0;
              chars_in_token_next = cap_nonzero ? sexp_pkg::MAX_CHARS_W'(1) : '0;
              push.v0             = cap_nonzero;
              push.r0             = '{token_kind: current_kind_next, has_char: 1'b1,
                                      char_out: c, token_end: 1'b0};
            end
          end
          default: begin
            to_idle = 1'b1;
          end
        endcase
      end
      if (to_idle) begin
        mode_next           = sexp_pkg::MODE_IDLE;
        escape_pending_next = 1'b0;
        current_kind_next   = sexp_pkg::KIND_ERROR;
        chars_in_token_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= sexp_pkg::MODE_IDLE;
      escape_pending  <= 1'b0;
      current_kind    <= sexp_pkg::KIND_ERROR;
      chars_in_token  <= '0;
      max_token_chars <= sexp_pkg::MAX_CHARS_RESET;
    end else begin
      mode           <= mode_next;
      escape_pending <= escape_pending_next;
      current_kind   <= current_kind_next;
      chars_in_token <= chars_in_token_next;
      if (cfg_write_en) begin
        max_token_chars <= cfg_write_data;
      end
    end
  end

  `ASSERT_IMPLIES(a_idle_clean, clk, rst, mode == sexp_pkg::MODE_IDLE, !escape_pending && chars_in_token == '0 && current_kind == sexp_pkg::KIND_ERROR)
  `ASSERT_IMPLIES(a_esc_in_string, clk, rst, escape_pending, mode == sexp_pkg::MODE_STRING)
  `ASSERT_IMPLIES(a_second_is_special, clk, rst, push.v1, push.v0 && push.r0.token_end && push.r1.token_kind == sexp_pkg::KIND_SPECIAL)
  `ASSERT_NEXT(a_eoi_idles, clk, rst, accept && item.end_of_input, mode == sexp_pkg::MODE_IDLE)

endmodule

>>> sv/sexp_result_queue.sv
// ---------------------------------------------------------------------------
// sexp_result_queue
// Small result queue: takes up to two results a cycle, delivers one while result_stall is low.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sexp_result_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  sexp_pkg::lex_push_t  push,
  output logic                 full_for_pair,
  output logic                 result_valid,
  input  logic                 result_stall,
  output sexp_pkg::out_item_t  result
);

  sexp_pkg::out_item_t                 mem [sexp_pkg::OUT_DEPTH];
  logic [sexp_pkg::OUT_PTR_W-1:0]      wr_ptr, rd_ptr;
  logic [sexp_pkg::OUT_CNT_W-1:0]      count, count_next;
  logic [sexp_pkg::OUT_PTR_W-1:0]      wr_ptr_plus1;
  logic                                pop;
  logic [1:0]                          n_push;

  assign wr_ptr_plus1  = wr_ptr + sexp_pkg::OUT_PTR_W'(1);
  assign n_push        = {1'b0, push.v0} + {1'b0, push.v1};
  assign result_valid  = count != '0;
  assign result        = mem[rd_ptr];
  assign pop           = result_valid && !result_stall;
  // hold new requests unless a two-result request still fits
  assign full_for_pair = count > sexp_pkg::OUT_CNT_W'(sexp_pkg::OUT_DEPTH - 2);
  assign count_next    = count + sexp_pkg::OUT_CNT_W'(n_push)
                         - sexp_pkg::OUT_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.v1) begin
      mem[wr_ptr_plus1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + sexp_pkg::OUT_PTR_W'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + sexp_pkg::OUT_PTR_W'(1);
      end
      count <= count_next;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= sexp_pkg::OUT_CNT_W'(sexp_pkg::OUT_DEPTH))
  `ASSERT_IMPLIES(a_no_overflow, clk, rst, push.v0, !full_for_pair)
  `ASSERT_NEXT(a_pop_drains, clk, rst, pop && !push.v0, count == $past(count) - sexp_pkg::OUT_CNT_W'(1))

endmodule

>>> sv/s_expression_tokenizer.sv
// ---------------------------------------------------------------------------
// s_expression_tokenizer
// Byte-stream s-expression lexer with per-token character cap.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel item_valid/item_stall/item carries one byte (or an
//   end-of-input mark) per request. Output channel result_valid/result_stall/
//   result delivers tagged token characters, token closes and errors.
//   cfg_write_en/cfg_write_data set max_token_chars; write only while idle.
// Timing:
//   One input request per cycle while item_stall is low. Each request's
//   results are registered in the result queue. A special character after
//   a symbol or number yields two results, which leave one per cycle while
//   result_stall is low; the 4-entry result queue sets how far the input may
//   run ahead, and item_stall rises once the queue holds more than two results.
// Reset (rst, synchronous): lexer returns to idle, the queue empties and
//   max_token_chars goes to 1023.
// Stall: while result_stall is high the head result holds; the input keeps
//   being taken until the queue has no room for a two-result request.
// ---------------------------------------------------------------------------
module s_expression_tokenizer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  sexp_pkg::in_item_t                item,
  output logic                              result_valid,
  input  logic                              result_stall,
  output sexp_pkg::out_item_t               result,
  input  logic                              cfg_write_en,
  input  logic [sexp_pkg::MAX_CHARS_W-1:0]  cfg_write_data
);

  sexp_pkg::lex_push_t push;
  logic                accept;

  assign accept = item_valid && !item_stall;

  sexp_lexer_core u_core (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .item           (item),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .push           (push)
  );

  sexp_result_queue u_queue (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full_for_pair (item_stall),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

endmodule
